FILE: rtl/core/wpg_pkg.sv
package wpg_pkg;

  localparam int OFFSET_WIDTH      = 32;
  localparam int SUM_WIDTH         = (OFFSET_WIDTH + 2 > 33) ? OFFSET_WIDTH + 2 : 33;
  localparam int FILE_LENGTH_WIDTH = 31;
  localparam int GAIN_WIDTH        = 17;
  localparam int CFG_INDEX_WIDTH   = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILE_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN        = 1'd1;

  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 17'd20972;
  localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = 17'd65536;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        pair;
    logic [15:0] sample;
  } cmd_t;

endpackage

FILE: rtl/core/wpg_front.sv
module wpg_front
  import wpg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  logic                         in_sof,
  input  logic [FILE_LENGTH_WIDTH-1:0] file_length,
  output logic                         push,
  output cmd_t                         push_cmd,
  input  logic                         q_full
);

  typedef enum logic [4:0] {
    PH_HEAD = 5'b00001,
    PH_SCAN = 5'b00010,
    PH_CHDR = 5'b00100,
    PH_DATA = 5'b01000,
    PH_PASS = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [OFFSET_WIDTH-1:0] pos;
    phase_t                  phase;
    logic [31:0]             tag;
    logic [23:0]             clen;
    logic [2:0]              hidx;
    logic [OFFSET_WIDTH:0]   next_hdr;
    logic                    fmt_seen;
    logic [4:0]              fmt_idx;
    logic [15:0]             fmt_code;
    logic [15:0]             bits;
    logic [OFFSET_WIDTH-1:0] data_end;
    logic [7:0]              held;
    logic                    held_valid;
    logic                    hdr_ok;
  } state_t;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [4:0]  FMT_IDX_SAT    = 5'd16;
  localparam logic [4:0]  FMT_IDX_READY  = 5'd15;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] FMT_BITS16     = 16'd16;
  localparam logic [2:0]  HIDX_LAST      = 3'd7;

  localparam logic [OFFSET_WIDTH-1:0] POS_MAX   = '1;
  localparam logic [SUM_WIDTH-1:0]    POS_MAX_W =
    {{(SUM_WIDTH-OFFSET_WIDTH){1'b0}}, POS_MAX};
  localparam logic [SUM_WIDTH-1:0]    MIN_LEN   = SUM_WIDTH'(44);

  localparam state_t ST_RESET = '{
    pos:        '0,
    phase:      PH_HEAD,
    tag:        '0,
    clen:       '0,
    hidx:       '0,
    next_hdr:   (OFFSET_WIDTH+1)'(12),
    fmt_seen:   1'b0,
    fmt_idx:    '0,
    fmt_code:   '0,
    bits:       '0,
    data_end:   '0,
    held:       '0,
    held_valid: 1'b0,
    hdr_ok:     1'b0
  };

  state_t st;
  state_t st_cur;
  state_t st_next;

  logic                 accept;
  logic                 emit_none;
  logic                 emit_pair;
  logic [SUM_WIDTH-1:0] pos_w;
  logic [SUM_WIDTH-1:0] len_w;
  logic [SUM_WIDTH-1:0] fl_w;
  logic [SUM_WIDTH-1:0] chunk_end;
  logic [31:0]          tag_in;
  logic [31:0]          size;
  logic [15:0]          code_n;
  logic [15:0]          bits_n;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign st_cur    = in_sof ? ST_RESET : st;
  assign pos_w     = {{(SUM_WIDTH-OFFSET_WIDTH){1'b0}}, st_cur.pos};
  assign fl_w      = {{(SUM_WIDTH-FILE_LENGTH_WIDTH){1'b0}}, file_length};
  assign len_w     = (fl_w > POS_MAX_W) ? POS_MAX_W : fl_w;
  assign tag_in    = {st_cur.tag[23:0], in_byte};
  assign size      = {in_byte, st_cur.clen};
  assign chunk_end = pos_w + SUM_WIDTH'(1) + {{(SUM_WIDTH-32){1'b0}}, size};

  always_comb begin
    st_next   = st_cur;
    emit_none = 1'b0;
    emit_pair = 1'b0;
    code_n    = st_cur.fmt_code;
    bits_n    = st_cur.bits;

    // capture format fields as they stream by
    if (st_cur.fmt_seen) begin
      unique case (st_cur.fmt_idx)
        5'd0:    code_n[7:0]  = in_byte;
        5'd1:    code_n[15:8] = in_byte;
        5'd14:   bits_n[7:0]  = in_byte;
        5'd15:   bits_n[15:8] = in_byte;
        default: begin
        end
      endcase
      if (st_cur.fmt_idx != FMT_IDX_SAT) begin
        st_next.fmt_idx = st_cur.fmt_idx + 5'd1;
      end
    end
    st_next.fmt_code = code_n;
    st_next.bits     = bits_n;

    unique case (st_cur.phase)
      PH_HEAD: begin
        if (st_cur.pos == '0 && len_w < MIN_LEN) begin
          st_next.phase = PH_PASS;
        end else begin
          st_next.tag = tag_in;
          if (st_cur.pos == OFFSET_WIDTH'(3)) begin
            st_next.hdr_ok = (tag_in == TAG_RIFF);
            if (tag_in != TAG_RIFF) st_next.phase = PH_PASS;
          end else if (st_cur.pos >= OFFSET_WIDTH'(11)) begin
            if (tag_in == TAG_WAVE && st_cur.hdr_ok) begin
              st_next.phase = PH_SCAN;
            end else begin
              st_next.hdr_ok = 1'b0;
              st_next.phase  = PH_PASS;
            end
          end
        end
      end
      PH_SCAN: begin
        if (pos_w == {{(SUM_WIDTH-OFFSET_WIDTH-1){1'b0}}, st_cur.next_hdr}) begin
          if (pos_w + SUM_WIDTH'(8) > len_w) begin
            st_next.phase = PH_PASS;
          end else begin
            st_next.tag   = {24'd0, in_byte};
            st_next.clen  = '0;
            st_next.hidx  = 3'd1;
            st_next.phase = PH_CHDR;
          end
        end
      end
      PH_CHDR: begin
        st_next.hidx = st_cur.hidx + 3'd1;
        if (!st_cur.hidx[2]) begin
          st_next.tag = tag_in;
        end else begin
          unique case (st_cur.hidx[1:0])
            2'd0:    st_next.clen[7:0]   = in_byte;
            2'd1:    st_next.clen[15:8]  = in_byte;
            2'd2:    st_next.clen[23:16] = in_byte;
            default: st_next.clen        = st_cur.clen;
          endcase
        end
        if (st_cur.hidx == HIDX_LAST) begin
          if (chunk_end > len_w) begin
            st_next.phase = PH_PASS;
          end else if (st_cur.tag == TAG_DATA) begin
            st_next.data_end   = chunk_end[OFFSET_WIDTH-1:0];
            st_next.held_valid = 1'b0;
            if (st_cur.fmt_seen && st_cur.fmt_idx >= FMT_IDX_READY &&
                code_n == FMT_PCM && bits_n == FMT_BITS16) begin
              st_next.phase = PH_DATA;
            end else begin
              st_next.phase = PH_PASS;
            end
          end else begin
            if (st_cur.tag == TAG_FMT) begin
              st_next.fmt_seen = 1'b1;
              st_next.fmt_idx  = '0;
            end
            st_next.next_hdr = chunk_end[OFFSET_WIDTH:0] + (OFFSET_WIDTH+1)'(size[0]);
            st_next.phase    = PH_SCAN;
          end
        end
      end
      PH_DATA: begin
        if (st_cur.held_valid) begin
          emit_pair          = 1'b1;
          st_next.held_valid = 1'b0;
        end else if (pos_w >= {{(SUM_WIDTH-OFFSET_WIDTH){1'b0}}, st_cur.data_end}) begin
          st_next.phase = PH_PASS;
        end else if (pos_w + SUM_WIDTH'(1) <
                     {{(SUM_WIDTH-OFFSET_WIDTH){1'b0}}, st_cur.data_end}) begin
          st_next.held       = in_byte;
          st_next.held_valid = 1'b1;
          emit_none          = 1'b1;
        end
      end
      PH_PASS: begin
        st_next.phase = PH_PASS;
      end
      default: begin
        st_next.phase = PH_PASS;
      end
    endcase

    // saturate position and stop parsing there
    if (st_cur.pos != POS_MAX) begin
      st_next.pos = st_cur.pos + OFFSET_WIDTH'(1);
    end else begin
      st_next.phase      = PH_PASS;
      st_next.held_valid = 1'b0;
    end
  end

  assign push     = accept && !emit_none;
  assign push_cmd = '{pair:   emit_pair,
                      sample: emit_pair ? {in_byte, st_cur.held} : {8'h00, in_byte}};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  a_held_in_data: assert property (@(posedge clk) disable iff (rst)
    st.held_valid |-> st.phase == PH_DATA)
    else $error("held sample byte outside data phase");

  a_data_needs_fmt: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_DATA |-> st.hdr_ok && st.fmt_seen)
    else $error("data phase without header or format");

endmodule

FILE: rtl/core/wpg_queue.sv
module wpg_queue
  import wpg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t                    mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr;
  logic [QPTR_WIDTH-1:0]   rd_ptr;
  logic [QCOUNT_WIDTH-1:0] count;
  logic [QCOUNT_WIDTH-1:0] count_next;

  assign full  = (count == QCOUNT_WIDTH'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop)      count_next = count + QCOUNT_WIDTH'(1);
    else if (pop && !push) count_next = count - QCOUNT_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_WIDTH'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_WIDTH'(1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("queue underflow");

endmodule

FILE: rtl/core/wpg_back.sv
module wpg_back
  import wpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [GAIN_WIDTH-1:0] gain,
  input  logic                  q_avail,
  input  cmd_t                  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  localparam logic [16:0] R_NEG_MAX = 17'd32768;
  localparam logic [16:0] R_POS_MAX = 17'd32767;
  localparam logic [32:0] ROUND_BIAS = 33'd32768;

  logic                  m_valid;
  logic                  m_pair;
  logic                  m_neg;
  logic [32:0]           m_prod;
  logic [7:0]            m_byte;
  logic                  m_ready;
  logic                  load;

  logic [GAIN_WIDTH-1:0] g;
  logic [15:0]           mag;
  logic [32:0]           prod;
  logic [32:0]           rnd;
  logic [16:0]           r;
  logic [16:0]           r_clip;
  logic [15:0]           res;

  logic                  ovalid;
  logic                  olast;
  logic [7:0]            obyte;
  logic                  pend;
  logic [7:0]            obyte_hi;

  assign g    = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;
  assign mag  = q_head.sample[15] ? (~q_head.sample + 16'd1) : q_head.sample;
  assign prod = mag * g;

  assign rnd = m_prod + ROUND_BIAS;
  assign r   = rnd[32:16];

  always_comb begin
    if (m_neg) begin
      r_clip = (r > R_NEG_MAX) ? R_NEG_MAX : r;
      res    = ~r_clip[15:0] + 16'd1;
    end else begin
      r_clip = (r > R_POS_MAX) ? R_POS_MAX : r;
      res    = r_clip[15:0];
    end
  end

  assign load    = m_valid && (!ovalid || (out_ready && !pend));
  assign m_ready = !m_valid || load;
  assign q_pop   = q_avail && m_ready;

  assign out_valid = ovalid;
  assign out_byte  = obyte;
  assign out_last  = olast;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_pair <= q_head.pair;
      m_neg  <= q_head.sample[15];
      m_prod <= prod;
      m_byte <= q_head.sample[7:0];
    end
    if (load) begin
      if (m_pair) begin
        obyte    <= res[7:0];
        olast    <= 1'b0;
        obyte_hi <= res[15:8];
      end else begin
        obyte <= m_byte;
        olast <= 1'b1;
      end
    end else if (ovalid && out_ready && pend) begin
      obyte <= obyte_hi;
      olast <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      ovalid  <= 1'b0;
      pend    <= 1'b0;
    end else begin
      if (m_ready) m_valid <= q_pop;
      if (load) begin
        ovalid <= 1'b1;
        pend   <= m_pair;
      end else if (ovalid && out_ready) begin
        if (pend) pend   <= 1'b0;
        else      ovalid <= 1'b0;
      end
    end
  end

  a_pend_valid: assert property (@(posedge clk) disable iff (rst)
    pend |-> ovalid)
    else $error("high byte pending without a low byte on the output");

  a_pair_split: assert property (@(posedge clk) disable iff (rst)
    load && m_pair |=> ovalid && pend && !olast)
    else $error("scaled sample not split into two bytes");

endmodule

FILE: rtl/core/wav_pcm16_gain_stream.sv
// Streams a WAV file byte by byte and passes it through, scaling the samples of a 16-bit PCM
// data chunk by the Q16 gain register (65536 is unity, larger values act as unity) with
// rounding and saturation. The parser checks the RIFF/WAVE header against file_length, walks
// the chunk headers and enables scaling only at a data chunk that fits and follows a complete
// PCM16 fmt chunk; anything else passes unchanged. A byte with tuser set restarts parsing. One
// byte is accepted per cycle unless the queue is full, and one byte leaves per cycle unless
// m_tready is low; the low byte of a sample produces nothing and its high byte produces both
// scaled bytes, the high one after the low one has been taken. Each byte to be sent on is written
// into a four-entry queue, from which it is loaded into the multiply stage and then the output
// register. Input stalls only while the queue is full. Write file_length and gain only while
// the block is idle.
module wav_pcm16_gain_stream
  import wpg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte
  input  logic                         s_tuser,   // start_of_file
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,   // out_byte
  output logic                         m_tlast,   // last_of_run
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [FILE_LENGTH_WIDTH-1:0] cfg_wdata
);

  logic [FILE_LENGTH_WIDTH-1:0] file_length;
  logic [GAIN_WIDTH-1:0]        gain;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_avail;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
      gain        <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILE_LENGTH: file_length <= cfg_wdata;
        REG_GAIN:        gain        <= cfg_wdata[GAIN_WIDTH-1:0];
      endcase
    end
  end

  wpg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_sof      (s_tuser),
    .file_length (file_length),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full)
  );

  wpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  wpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

FILE: bench/pcm16_gain_checker.sv
`timescale 1ns / 1ps
module pcm16_gain_checker
  import wpg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte
  input  logic                         s_tuser,   // start_of_file
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [7:0]                   m_tdata,   // out_byte
  input  logic                         m_tlast,   // last_of_run
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [FILE_LENGTH_WIDTH-1:0] cfg_wdata,
  output int                           mismatches,
  output int                           pending,
  output int                           checked,
  output int                           scaled
);

  localparam logic [63:0] POS_LIMIT       = 64'hFFFF_FFFF >> (32 - OFFSET_WIDTH);
  localparam logic [63:0] MIN_FILE_BYTES  = 64'd44;
  localparam logic [63:0] CHUNK_HDR_BYTES = 64'd8;
  localparam logic [63:0] FMT_FIELD_BYTES = 64'd16;
  localparam logic [63:0] FIRST_CHUNK_AT  = 64'd12;
  localparam logic [15:0] PCM_CODE        = 16'd1;
  localparam logic [15:0] PCM_BITS        = 16'd16;
  localparam logic [31:0] TAG_RIFF        = "RIFF";
  localparam logic [31:0] TAG_WAVE        = "WAVE";
  localparam logic [31:0] TAG_FMT         = "fmt ";
  localparam logic [31:0] TAG_DATA        = "data";

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_SCAN,
    PH_CHUNK_HDR,
    PH_SAMPLES,
    PH_THROUGH
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_beat_t;

  logic [FILE_LENGTH_WIDTH-1:0] file_len;
  logic [GAIN_WIDTH-1:0]        gain_q;

  logic [63:0]  position;
  parse_phase_t phase;
  logic [31:0]  tag_sr;
  logic [31:0]  chunk_len;
  logic [63:0]  next_hdr;
  logic [63:0]  fmt_start;
  logic         fmt_seen;
  logic [15:0]  fmt_code;
  logic [15:0]  fmt_bits;
  logic [63:0]  data_end;
  logic [7:0]   held_byte;
  logic         held_valid;
  logic         hdr_ok;

  out_beat_t expected_out[$];
  out_beat_t want;

  function automatic void restart_parse();
    position   = '0;
    phase      = PH_HEADER;
    tag_sr     = '0;
    chunk_len  = '0;
    next_hdr   = FIRST_CHUNK_AT;
    fmt_start  = '0;
    fmt_seen   = 1'b0;
    fmt_code   = '0;
    fmt_bits   = '0;
    data_end   = '0;
    held_byte  = '0;
    held_valid = 1'b0;
    hdr_ok     = 1'b0;
  endfunction

  function automatic logic [15:0] scaled_sample(input logic [15:0] raw);
    logic [16:0] g;
    logic [16:0] mag;
    logic [33:0] r;
    g   = (gain_q > GAIN_UNITY) ? GAIN_UNITY : gain_q;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    r   = ({17'd0, mag} * {17'd0, g} + 34'd32768) >> 16;
    if (raw[15]) begin
      if (r > 34'd32768) r = 34'd32768;
      return 16'(17'h10000 - r[16:0]);
    end
    if (r > 34'd32767) r = 34'd32767;
    return r[15:0];
  endfunction

  task automatic predict_out_bytes(input logic [7:0] b, input logic sof);
    logic [63:0] p;
    logic [63:0] len;
    logic [63:0] k;
    logic [63:0] payload;
    logic [63:0] size;
    logic [15:0] s;
    int          n;
    n = 1;
    if (sof) restart_parse();
    p   = position;
    len = 64'(file_len);
    if (len > POS_LIMIT) len = POS_LIMIT;

    // the fmt fields are captured by position, whatever chunk they land in
    if (fmt_seen) begin
      if (p == fmt_start) fmt_code[7:0] = b;
      else if (p == fmt_start + 1) fmt_code[15:8] = b;
      else if (p == fmt_start + 14) fmt_bits[7:0] = b;
      else if (p == fmt_start + 15) fmt_bits[15:8] = b;
    end

    case (phase)
      PH_HEADER: begin
        if (p == 0 && len < MIN_FILE_BYTES) begin
          phase = PH_THROUGH;
        end else begin
          tag_sr = {tag_sr[23:0], b};
          if (p == 3) begin
            hdr_ok = (tag_sr == TAG_RIFF);
            if (!hdr_ok) phase = PH_THROUGH;
          end else if (p >= 11) begin
            if (tag_sr == TAG_WAVE && hdr_ok) begin
              phase = PH_CHUNK_SCAN;
            end else begin
              hdr_ok = 1'b0;
              phase  = PH_THROUGH;
            end
          end
        end
      end
      PH_CHUNK_SCAN: begin
        if (p == next_hdr) begin
          if (p + CHUNK_HDR_BYTES > len) begin
            phase = PH_THROUGH;
          end else begin
            tag_sr    = {24'd0, b};
            chunk_len = '0;
            phase     = PH_CHUNK_HDR;
          end
        end
      end
      PH_CHUNK_HDR: begin
        k = p - next_hdr;
        if (k < 4) tag_sr = {tag_sr[23:0], b};
        else chunk_len = chunk_len | (32'(b) << (8 * (k - 4)));
        if (k >= 7) begin
          payload = p + 1;
          size    = 64'(chunk_len);
          if (payload + size > len) begin
            phase = PH_THROUGH;
          end else if (tag_sr == TAG_DATA) begin
            data_end   = payload + size;
            held_valid = 1'b0;
            if (fmt_seen && fmt_start + FMT_FIELD_BYTES <= payload &&
                fmt_code == PCM_CODE && fmt_bits == PCM_BITS)
              phase = PH_SAMPLES;
            else
              phase = PH_THROUGH;
          end else begin
            if (tag_sr == TAG_FMT) begin
              fmt_seen  = 1'b1;
              fmt_start = payload;
            end
            next_hdr = payload + size + 64'(size[0]);
            phase    = PH_CHUNK_SCAN;
          end
        end
      end
      PH_SAMPLES: begin
        if (held_valid) begin
          s = scaled_sample({b, held_byte});
          held_valid = 1'b0;
          expected_out.push_back('{value: s[7:0], last: 1'b0});
          expected_out.push_back('{value: s[15:8], last: 1'b1});
          scaled++;
          n = 2;
        end else if (p >= data_end) begin
          phase = PH_THROUGH;
        end else if (p + 1 < data_end) begin
          held_byte  = b;
          held_valid = 1'b1;
          n = 0;
        end
      end
      default: phase = PH_THROUGH;
    endcase

    if (p < POS_LIMIT) begin
      position = p + 1;
    end else begin
      position   = POS_LIMIT;
      phase      = PH_THROUGH;
      held_valid = 1'b0;
    end

    if (n == 1) expected_out.push_back('{value: b, last: 1'b1});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      file_len = '0;
      gain_q   = GAIN_RESET;
      expected_out.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILE_LENGTH: file_len = cfg_wdata;
          REG_GAIN:        gain_q   = cfg_wdata[GAIN_WIDTH-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_out_bytes(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none actual out_byte %02h last_of_run %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_out.pop_front();
          checked++;
          if (m_tdata !== want.value) begin
            mismatches++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.value, m_tdata);
          end
          if (m_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last, m_tlast);
          end
        end
      end
    end
    pending = expected_out.size();
  end

endmodule

FILE: bench/tb_wav_pcm16_gain_stream.sv
`timescale 1ns / 1ps
module tb_wav_pcm16_gain_stream;
  import wpg_pkg::*;

  localparam int          ITEM_TARGET   = 1550;
  localparam int          TAIL_ITEMS    = 200;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [15:0] WAVE_PCM      = 16'd1;
  localparam logic [15:0] WAVE_FLOAT    = 16'd3;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [7:0]                   s_tdata;   // data_byte
  logic                         s_tuser;   // start_of_file
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [7:0]                   m_tdata;   // out_byte
  logic                         m_tlast;   // last_of_run
  logic                         cfg_we;
  logic [CFG_INDEX_WIDTH-1:0]   cfg_index;
  logic [FILE_LENGTH_WIDTH-1:0] cfg_wdata;

  int   mismatches;
  int   pending;
  int   checked;
  int   scaled;
  int   sent_bytes;
  int   files_sent;
  int   stall_left;
  bit   idle_on = 1'b1;
  logic [7:0] file_bytes[$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  wav_pcm16_gain_stream uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pcm16_gain_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .scaled     (scaled)
  );

  initial begin
    #5_000_000;
    $display("timeout with %0d output bytes outstanding", pending);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_file(input int count);
    for (int i = 0; i < count; i++) send_byte(file_bytes[i], i == 0);
  endtask

  // hold off until every expected byte is out, then let a held low byte settle
  task automatic drain_results;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [FILE_LENGTH_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_le16(input logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endfunction

  function automatic void add_le32(input logic [31:0] v);
    add_le16(v[15:0]);
    add_le16(v[31:16]);
  endfunction

  function automatic void add_tag(input logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endfunction

  function automatic void add_filler(input int count);
    for (int i = 0; i < count; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_junk_chunk();
    int len;
    len = $urandom_range(0, 9);
    add_tag($urandom_range(0, 1) ? "LIST" : "fact");
    add_le32(32'(len));
    add_filler(len + (len & 1));
  endfunction

  function automatic void add_fmt(input int len, input logic [15:0] code,
                                  input logic [15:0] bits);
    logic [127:0] canon;
    canon = {bits, 16'($urandom_range(1, 4)), 32'($urandom), 32'd44100,
             16'($urandom_range(1, 2)), code};
    add_tag("fmt ");
    add_le32(32'(len));
    for (int i = 0; i < len && i < 16; i++) file_bytes.push_back(canon[8*i +: 8]);
    if (len > 16) add_filler(len - 16);
    if (len % 2 == 1) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return $urandom_range(0, 1) ? 16'h0001 : 16'h8001;
      4:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [FILE_LENGTH_WIDTH-1:0] flen;
    logic [GAIN_WIDTH-1:0]        gain_val;
    logic [FILE_LENGTH_WIDTH-GAIN_WIDTH-1:0] gain_pad;
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] data_field;
    logic [15:0] code;
    logic [15:0] bits;
    int          kind;
    int          fmt_len;
    int          data_len;
    int          full;
    int          count;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FILE_LENGTH;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short file after reset, no start mark
    send_byte("R", 1'b0);
    send_byte("I", 1'b0);
    send_byte("F", 1'b0);
    drain_results;
    write_reg(REG_FILE_LENGTH, FILE_LENGTH_WIDTH'(43));
    file_bytes.delete();
    add_tag("RIFF");
    send_file(4);
    drain_results;
    write_reg(REG_FILE_LENGTH, FILE_LENGTH_WIDTH'(64));
    file_bytes.delete();
    add_tag("RIFX");
    send_file(4);
    file_bytes.delete();
    add_tag("RIFF");
    add_le32(32'd56);
    add_tag("WAVX");
    send_file(12);

    while (sent_bytes < ITEM_TARGET) begin
      idle_on = (sent_bytes > ITEM_TARGET - TAIL_ITEMS) ? 1'b0
                                                       : ($urandom_range(0, 3) != 0);
      file_bytes.delete();
      kind     = $urandom_range(0, 15);
      riff_tag = "RIFF";
      wave_tag = "WAVE";
      code     = WAVE_PCM;
      bits     = 16'd16;
      case ($urandom_range(0, 3))
        0:       fmt_len = 18;
        1:       fmt_len = 17;
        default: fmt_len = 16;
      endcase

      if (kind == 0) begin
        add_filler($urandom_range(4, 30));
      end else begin
        if (kind == 1) begin
          if ($urandom_range(0, 1)) riff_tag[5'($urandom_range(0, 31))] ^= 1'b1;
          else wave_tag[5'($urandom_range(0, 31))] ^= 1'b1;
        end
        if (kind == 2) begin
          if ($urandom_range(0, 1))
            code = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
          else
            bits = $urandom_range(0, 1) ? 16'd24 : 16'($urandom_range(17, 65535));
        end
        if (kind == 3) fmt_len = $urandom_range(0, 15);
        add_tag(riff_tag);
        add_le32($urandom);
        add_tag(wave_tag);
        if ($urandom_range(0, 3) == 0) add_junk_chunk();
        if (kind == 5) begin
          add_fmt(16, $urandom_range(0, 1) ? WAVE_PCM : WAVE_FLOAT, 16'd16);
          code = $urandom_range(0, 1) ? WAVE_PCM : WAVE_FLOAT;
        end
        if (kind != 4) add_fmt(fmt_len, code, bits);
        if ($urandom_range(0, 3) == 0) add_junk_chunk();
        data_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 48);
        data_field = 32'(data_len);
        if (kind == 6)
          data_field = $urandom_range(0, 1) ? (32'hFFFF_0000 | 32'($urandom))
                                            : data_field + $urandom_range(1, 100);
        add_tag("data");
        add_le32(data_field);
        for (int i = 0; i + 1 < data_len; i += 2) add_le16(random_sample());
        if (data_len % 2 == 1) file_bytes.push_back(8'($urandom));
      end
      full = file_bytes.size();
      add_filler($urandom_range(0, 3));

      case ($urandom_range(0, 9))
        0:       flen = (full > 12) ? FILE_LENGTH_WIDTH'(full - $urandom_range(1, 12)) : '0;
        1:       flen = '1;
        2:       flen = FILE_LENGTH_WIDTH'($urandom_range(0, 43));
        3:       flen = FILE_LENGTH_WIDTH'(full + $urandom_range(1, 20));
        default: flen = FILE_LENGTH_WIDTH'(full);
      endcase
      count = file_bytes.size();
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);

      if (files_sent < 6 || $urandom_range(0, 3) != 0) begin
        drain_results;
        write_reg(REG_FILE_LENGTH, flen);
        if (files_sent < 6 || $urandom_range(0, 2) == 0) begin
          gain_pad = '0;
          case (files_sent < 6 ? files_sent : $urandom_range(6, 12))
            0: gain_val = GAIN_UNITY;
            1: gain_val = '0;
            2: begin
              gain_val = '1;
              gain_pad = (FILE_LENGTH_WIDTH-GAIN_WIDTH)'($urandom);
            end
            3: gain_val = 17'd1;
            4: gain_val = 17'd65535;
            5: gain_val = GAIN_RESET;
            default: begin
              gain_val = GAIN_WIDTH'($urandom_range(0, 65536));
              if ($urandom_range(0, 3) == 0)
                gain_pad = (FILE_LENGTH_WIDTH-GAIN_WIDTH)'($urandom);
            end
          endcase
          write_reg(REG_GAIN, {gain_pad, gain_val});
        end
      end
      send_file(count);
      files_sent++;
    end

    drain_results;
    $display("run covered %0d files in %0d input bytes;", files_sent, sent_bytes);
    $display("%0d output bytes checked, %0d samples scaled", checked, scaled);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/wpg_pkg.sv
rtl/core/wpg_front.sv
rtl/core/wpg_queue.sv
rtl/core/wpg_back.sv
rtl/core/wav_pcm16_gain_stream.sv
bench/pcm16_gain_checker.sv
bench/tb_wav_pcm16_gain_stream.sv
